// ===== sv/tsc_pkg.sv =====
// Shared widths, constants, stage bus type and accumulate helper for the sine/cosine core.
`default_nettype none
package tsc_pkg;

   localparam int ANGLE_W = 26;
   localparam int TERMS_W = 4;
   localparam int OUT_W   = 32;
   localparam int R_W     = 28;
   localparam int E_W     = 36;
   localparam int ACC_W   = 40;
   localparam int LAST_W  = 6;
   localparam int FRAC_W  = 24;
   localparam int DIG_W   = 20;
   localparam int QH_W    = E_W - DIG_W;
   localparam int C_W     = 33;
   localparam int REM_W   = 6;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [C_W-1:0] DEG2RAD_Q38 =
      C_W'(((((PI_Q60 >> 21) + 64'd1) >> 1) + 64'd90) / 64'd180);

   localparam logic [1:0] PH_COS_ADD = 2'd0;
   localparam logic [1:0] PH_SIN_ADD = 2'd1;
   localparam logic [1:0] PH_COS_SUB = 2'd2;
   localparam logic [1:0] PH_SIN_SUB = 2'd3;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic                    valid;
      logic                    neg;
      logic [LAST_W-1:0]       last;
      logic [R_W-1:0]          r;
      logic signed [ACC_W-1:0] sin_acc;
      logic signed [ACC_W-1:0] cos_acc;
      logic [E_W-1:0]          e;
   } tsc_bus_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sin_acc;
      logic signed [ACC_W-1:0] cos_acc;
   } tsc_acc_type;

   function automatic tsc_acc_type tsc_acc_step(input tsc_bus_type b, input logic [1:0] phase,
                                                input logic take);
      tsc_acc_type             res;
      logic signed [ACC_W-1:0] ev;
      ev = ACC_W'(b.e);
      res.sin_acc = b.sin_acc;
      res.cos_acc = b.cos_acc;
      if (take) begin
         unique case (phase)
            PH_COS_ADD: res.cos_acc = b.cos_acc + ev;
            PH_SIN_ADD: res.sin_acc = b.sin_acc + ev;
            PH_COS_SUB: res.cos_acc = b.cos_acc - ev;
            PH_SIN_SUB: res.sin_acc = b.sin_acc - ev;
            default:    res.sin_acc = b.sin_acc;
         endcase
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== sv/tsc_if.sv =====
// Request and response channel interfaces of the sine/cosine core.
`default_nettype none
interface tsc_req_if import tsc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_deg;
   logic [TERMS_W-1:0]        num_terms;
   modport source (output valid, angle_deg, num_terms, input ready);
   modport sink   (input valid, angle_deg, num_terms, output ready);
endinterface

interface tsc_rsp_if import tsc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] sine_value;
   logic signed [OUT_W-1:0] cosine_value;
   logic                    saturated;
   modport source (output valid, sine_value, cosine_value, saturated, input ready);
   modport sink   (input valid, sine_value, cosine_value, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/tsc_front.sv =====
// Front end: angle magnitude, term clamp and degree to radian conversion over two stages.
`default_nettype none
module tsc_front import tsc_pkg::*; #(
   parameter int MAX_TERMS = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      enable,
   input  wire logic                      in_valid,
   input  wire logic signed [ANGLE_W-1:0] angle_deg,
   input  wire logic [TERMS_W-1:0]        num_terms,
   output tsc_bus_type                    bus_out
);

   localparam int P_W = ANGLE_W + C_W;
   localparam logic [TERMS_W:0] TERMS_CAP = (TERMS_W+1)'(MAX_TERMS);

   logic               valid_ff, valid_in;
   logic               neg_ff, neg_in;
   logic [LAST_W-1:0]  last_ff, last_in;
   logic [P_W-1:0]     prod_ff, prod_in;
   logic [ANGLE_W-1:0] mag;
   logic [TERMS_W:0]   terms;
   logic [P_W:0]       rsum;
   tsc_bus_type        bus_ff, bus_in;

   always_comb begin
      neg_in   = angle_deg[ANGLE_W-1];
      mag      = neg_in ? ANGLE_W'(-angle_deg) : ANGLE_W'(angle_deg);
      terms    = ((TERMS_W+1)'(num_terms) > TERMS_CAP) ? TERMS_CAP : (TERMS_W+1)'(num_terms);
      last_in  = LAST_W'({terms, 1'b1});
      prod_in  = P_W'(mag) * P_W'(DEG2RAD_Q38);
      valid_in = in_valid;
   end

   always_comb begin
      rsum           = (P_W+1)'(prod_ff) + ((P_W+1)'(1) << 29);
      bus_in.valid   = valid_ff;
      bus_in.neg     = neg_ff;
      bus_in.last    = last_ff;
      bus_in.r       = rsum[30 +: R_W];
      bus_in.sin_acc = '0;
      bus_in.cos_acc = '0;
      bus_in.e       = E_W'(1) << FRAC_W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         bus_ff.valid <= 1'b0;
      end else if (enable) begin
         valid_ff     <= valid_in;
         bus_ff.valid <= bus_in.valid;
      end
      if (enable) begin
         neg_ff         <= neg_in;
         last_ff        <= last_in;
         prod_ff        <= prod_in;
         bus_ff.neg     <= bus_in.neg;
         bus_ff.last    <= bus_in.last;
         bus_ff.r       <= bus_in.r;
         bus_ff.sin_acc <= bus_in.sin_acc;
         bus_ff.cos_acc <= bus_in.cos_acc;
         bus_ff.e       <= bus_in.e;
      end
   end

   assign bus_out = bus_ff;

endmodule
`default_nettype wire

// ===== sv/tsc_term.sv =====
// One series term: accumulate the previous term, then form the next over five stages.
`default_nettype none
module tsc_term import tsc_pkg::*; #(
   parameter int K = 1
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  enable,
   input  tsc_bus_type bus_in,
   output tsc_bus_type bus_out
);

   localparam int PM_W = 2 * R_W - 10;
   localparam int T_W  = 2 * DIG_W;
   localparam int CP_W = DIG_W + C_W;
   localparam int EP_W = DIG_W + REM_W + C_W;
   localparam logic [LAST_W-1:0] PREV = LAST_W'(K - 1);
   localparam logic [1:0] PHASE = 2'(K - 1);
   localparam logic [C_W-1:0] M = C_W'(((64'd1 << 32) + 64'(K) - 64'd1) / 64'(K));
   localparam logic [63:0] HALF = 64'(K) << (FRAC_W - 1);

   tsc_bus_type a_ff, a_in, b_ff, c_ff, d_ff, e_ff, e_in;
   tsc_acc_type acc;
   logic [PM_W-1:0]  plo_ff, plo_in, phi_ff, phi_in;
   logic [63:0]      psum;
   logic [T_W-1:0]   t_ff, t_in;
   logic [CP_W-1:0]  c_prod;
   logic [DIG_W-1:0] qh_ff, qh_in, ca_ff, cb_ff, dqh_ff;
   logic [DIG_W-1:0] rem;
   logic [DIG_W+REM_W-1:0] x_ff, x_in;
   logic [EP_W-1:0]  e_prod;

   always_comb begin
      acc          = tsc_acc_step(bus_in, PHASE, bus_in.last >= PREV);
      a_in         = bus_in;
      a_in.sin_acc = acc.sin_acc;
      a_in.cos_acc = acc.cos_acc;
      plo_in       = PM_W'(bus_in.e[17:0]) * PM_W'(bus_in.r);
      phi_in       = PM_W'(bus_in.e[E_W-1:18]) * PM_W'(bus_in.r);
   end

   always_comb begin
      psum = {phi_ff, 18'b0} + 64'(plo_ff) + HALF;
      t_in = psum[63:FRAC_W];
   end

   always_comb begin
      c_prod = CP_W'(t_ff[T_W-1:DIG_W]) * CP_W'(M);
      qh_in  = c_prod[32 +: DIG_W];
   end

   always_comb begin
      rem  = ca_ff - DIG_W'(qh_ff * DIG_W'(K));
      x_in = {rem[REM_W-1:0], cb_ff};
   end

   always_comb begin
      e_prod = EP_W'(x_ff) * EP_W'(M);
      e_in   = d_ff;
      e_in.e = {dqh_ff[QH_W-1:0], e_prod[32 +: DIG_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
         d_ff.valid <= 1'b0;
         e_ff.valid <= 1'b0;
      end else if (enable) begin
         a_ff.valid <= a_in.valid;
         b_ff.valid <= a_ff.valid;
         c_ff.valid <= b_ff.valid;
         d_ff.valid <= c_ff.valid;
         e_ff.valid <= e_in.valid;
      end
      if (enable) begin
         a_ff.neg <= a_in.neg;  a_ff.last <= a_in.last;  a_ff.r <= a_in.r;
         a_ff.sin_acc <= a_in.sin_acc;  a_ff.cos_acc <= a_in.cos_acc;  a_ff.e <= a_in.e;
         b_ff.neg <= a_ff.neg;  b_ff.last <= a_ff.last;  b_ff.r <= a_ff.r;
         b_ff.sin_acc <= a_ff.sin_acc;  b_ff.cos_acc <= a_ff.cos_acc;  b_ff.e <= a_ff.e;
         c_ff.neg <= b_ff.neg;  c_ff.last <= b_ff.last;  c_ff.r <= b_ff.r;
         c_ff.sin_acc <= b_ff.sin_acc;  c_ff.cos_acc <= b_ff.cos_acc;  c_ff.e <= b_ff.e;
         d_ff.neg <= c_ff.neg;  d_ff.last <= c_ff.last;  d_ff.r <= c_ff.r;
         d_ff.sin_acc <= c_ff.sin_acc;  d_ff.cos_acc <= c_ff.cos_acc;  d_ff.e <= c_ff.e;
         e_ff.neg <= e_in.neg;  e_ff.last <= e_in.last;  e_ff.r <= e_in.r;
         e_ff.sin_acc <= e_in.sin_acc;  e_ff.cos_acc <= e_in.cos_acc;  e_ff.e <= e_in.e;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         t_ff   <= t_in;
         qh_ff  <= qh_in;
         ca_ff  <= t_ff[T_W-1:DIG_W];
         cb_ff  <= t_ff[DIG_W-1:0];
         x_ff   <= x_in;
         dqh_ff <= qh_ff;
      end
   end

   assign bus_out = e_ff;

   a_rem_below_k: assert property (@(posedge clock) disable iff (reset)
      c_ff.valid |-> (rem < DIG_W'(K)))
      else $error("term remainder not below divisor");

   a_term_fits: assert property (@(posedge clock) disable iff (reset)
      d_ff.valid |-> (dqh_ff[DIG_W-1:QH_W] == '0))
      else $error("term magnitude exceeds its register");

endmodule
`default_nettype wire

// ===== sv/tsc_back.sv =====
// Back end: add the last term, apply the angle sign, saturate and hold the result.
`default_nettype none
module tsc_back import tsc_pkg::*; #(
   parameter int KLAST = 25
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  tsc_bus_type             bus_in,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] sine_value,
   output logic signed [OUT_W-1:0] cosine_value,
   output logic                    saturated
);

   localparam logic [LAST_W-1:0] KL = LAST_W'(KLAST);
   localparam logic [1:0] PHASE = 2'(KLAST);
   localparam logic signed [ACC_W-1:0] WMAX = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] WMIN = ACC_W'(OUT_MIN);

   tsc_acc_type acc, z_ff;
   logic        zv_ff, zneg_ff;
   logic signed [ACC_W-1:0] sinv;
   logic signed [OUT_W-1:0] sin_in, cos_in;
   logic        sat_in;
   logic        v_ff;
   logic signed [OUT_W-1:0] sin_ff, cos_ff;
   logic        sat_ff;

   always_comb begin
      acc = tsc_acc_step(bus_in, PHASE, bus_in.last >= KL);
   end

   always_comb begin
      sinv   = zneg_ff ? -z_ff.sin_acc : z_ff.sin_acc;
      sat_in = 1'b0;
      if (sinv > WMAX) begin
         sin_in = OUT_MAX;
         sat_in = 1'b1;
      end else if (sinv < WMIN) begin
         sin_in = OUT_MIN;
         sat_in = 1'b1;
      end else begin
         sin_in = OUT_W'(sinv);
      end
      if (z_ff.cos_acc > WMAX) begin
         cos_in = OUT_MAX;
         sat_in = 1'b1;
      end else if (z_ff.cos_acc < WMIN) begin
         cos_in = OUT_MIN;
         sat_in = 1'b1;
      end else begin
         cos_in = OUT_W'(z_ff.cos_acc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zv_ff <= 1'b0;
         v_ff  <= 1'b0;
      end else if (enable) begin
         zv_ff <= bus_in.valid;
         v_ff  <= zv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff    <= acc;
         zneg_ff <= bus_in.neg;
         sin_ff  <= sin_in;
         cos_ff  <= cos_in;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid    = v_ff;
   assign sine_value   = sin_ff;
   assign cosine_value = cos_ff;
   assign saturated    = sat_ff;

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (v_ff && sat_ff) |-> (sin_ff == OUT_MAX || sin_ff == OUT_MIN ||
                            cos_ff == OUT_MAX || cos_ff == OUT_MIN))
      else $error("saturation flag without a clipped value");

endmodule
`default_nettype wire

// ===== sv/taylor_sine_cosine_core.sv =====
// Taylor-series sine and cosine core. An item (angle in degrees, Q10.16, and a term count
// clamped to MAX_TERMS) enters a fully pipelined datapath: two stages turn the angle into
// radians, then each of the 2*MAX_TERMS+1 series terms has a five-stage unit (split
// multiply by the radian value, rounding add, two-digit division by the term index), and
// two final stages apply the sign and saturate to Q8.24. One item can enter every cycle
// unless the pipeline is held. The whole pipeline holds while a finished result waits on
// the response channel.
`default_nettype none
module taylor_sine_cosine_core import tsc_pkg::*; #(
   parameter int MAX_TERMS = 12
) (
   input wire logic  clock,
   input wire logic  reset,
   tsc_req_if.sink   req_chan,
   tsc_rsp_if.source rsp_chan
);

   localparam int KLAST = 2 * MAX_TERMS + 1;

   logic        enable;
   logic        rsp_valid;
   tsc_bus_type chain [0:KLAST];

   assign enable         = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = enable;
   assign rsp_chan.valid = rsp_valid;

   tsc_front #(.MAX_TERMS(MAX_TERMS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_chan.valid),
      .angle_deg (req_chan.angle_deg),
      .num_terms (req_chan.num_terms),
      .bus_out   (chain[0])
   );

   for (genvar k = 1; k <= KLAST; k++) begin : g_term
      tsc_term #(.K(k)) u_term (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .bus_in  (chain[k-1]),
         .bus_out (chain[k])
      );
   end

   tsc_back #(.KLAST(KLAST)) u_back (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .bus_in       (chain[KLAST]),
      .out_valid    (rsp_valid),
      .sine_value   (rsp_chan.sine_value),
      .cosine_value (rsp_chan.cosine_value),
      .saturated    (rsp_chan.saturated)
   );

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(chain[0]))
      else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
